>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition now implies a consequence in the next cycle
`define PFLA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

>>> src/pfla_pkg.sv
package pfla_pkg;

	// default geometry
	localparam int unsigned NUM_PAGES_DEF  = 32768;
	localparam int unsigned PAGE_SHIFT_DEF = 12;

	// fixed field widths
	localparam int ADDR_W   = 39;
	localparam int STATUS_W = 2;
	localparam int PAGES_W  = 16;
	localparam int BYTES_W  = 28;
	localparam int DATA_W   = 64;
	localparam int PADDR_W  = 4;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	// request codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// register select, taken from paddr bit 3
	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	// list update requested for the current transaction
	typedef struct packed {
		logic push;
		logic pop;
	} list_op_t;

endpackage

>>> src/pfla_addr_check.sv
module pfla_addr_check #(
	parameter int unsigned NUM_PAGES  = pfla_pkg::NUM_PAGES_DEF,
	parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEF,
	parameter int unsigned IDX_W      = $clog2(NUM_PAGES)
) (
	input  logic [pfla_pkg::ADDR_W-1:0] page_addr,
	input  logic [pfla_pkg::ADDR_W-1:0] low_bound,
	input  logic [pfla_pkg::ADDR_W-1:0] high_bound,
	output logic [pfla_pkg::ADDR_W-1:0] base,
	output logic                        addr_ok,
	output logic [IDX_W-1:0]            page_idx
);
	import pfla_pkg::*;

	logic [ADDR_W-1:0] diff;
	logic [ADDR_W-1:0] num;
	logic              aligned;
	logic              above_low;
	logic              below_high;
	logic              in_range;

	// page base is the lower bound rounded down to a page
	assign base = {low_bound[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

	// page number relative to the base
	assign diff = page_addr - base;
	assign num  = diff >> PAGE_SHIFT;

	// free address checks
	assign aligned    = (page_addr[PAGE_SHIFT-1:0] == '0);
	assign above_low  = (page_addr >= low_bound);
	assign below_high = (page_addr < high_bound);
	assign in_range   = (num < ADDR_W'(NUM_PAGES));

	assign addr_ok  = aligned && above_low && below_high && in_range;
	assign page_idx = num[IDX_W-1:0];

endmodule

>>> src/pfla_list.sv
module pfla_list #(
	parameter int unsigned NUM_PAGES = pfla_pkg::NUM_PAGES_DEF,
	parameter int unsigned IDX_W     = $clog2(NUM_PAGES),
	parameter int unsigned CNT_W     = $clog2(NUM_PAGES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pfla_pkg::list_op_t op,
	input  logic [IDX_W-1:0]   push_idx,
	output logic [IDX_W-1:0]   head_idx,
	output logic               head_valid,
	output logic [CNT_W-1:0]   count_next
);
	import pfla_pkg::*;

	// link memory entry: valid bit over the next page index
	logic [IDX_W:0]   link_mem [NUM_PAGES];
	logic [IDX_W:0]   rd_q;
	logic [IDX_W:0]   byp_val_q;
	logic             byp_q;

	logic [IDX_W-1:0] head_q;
	logic             head_valid_q;
	logic [CNT_W-1:0] count_q;

	logic [IDX_W-1:0] head_d;
	logic             head_valid_d;
	logic [IDX_W:0]   nxt;

	// link of the current head: just written on a push, else from memory
	assign nxt = byp_q ? byp_val_q : rd_q;

	// next head
	always_comb begin
		head_d       = head_q;
		head_valid_d = head_valid_q;
		if (op.push) begin
			head_d       = push_idx;
			head_valid_d = 1'b1;
		end else if (op.pop) begin
			head_d       = nxt[IDX_W-1:0];
			head_valid_d = nxt[IDX_W];
		end
	end

	// saturating free page count
	always_comb begin
		count_next = count_q;
		if (op.push && (count_q < CNT_W'(NUM_PAGES))) begin
			count_next = count_q + CNT_W'(1);
		end else if (op.pop && (count_q != '0)) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// head, count and bypass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			head_valid_q <= 1'b0;
			count_q      <= '0;
			byp_q        <= 1'b0;
		end else begin
			head_q       <= head_d;
			head_valid_q <= head_valid_d;
			count_q      <= count_next;
			byp_q        <= op.push;
		end
	end

	// old head becomes the link of a pushed page
	always_ff @(posedge clk) begin
		byp_val_q <= {head_valid_q, head_q};
	end

	// link memory: write on push, prefetch the link of the next head
	always_ff @(posedge clk) begin
		if (op.push) begin
			link_mem[push_idx] <= {head_valid_q, head_q};
		end
		rd_q <= link_mem[head_d];
	end

	assign head_idx   = head_q;
	assign head_valid = head_valid_q;

endmodule

>>> src/page_free_list_allocator.sv
// LIFO page allocator over a linked free list.
// Request channel: in_valid/in_stall with cmd and page_addr. cmd alloc pops the
// list head, cmd free checks page_addr and pushes it. One result per request on
// out_valid/out_stall: status, alloc_addr, free_pages and free_bytes.
// A request is held in the request register and its result is registered in the
// result register when that is free. Throughput: one request per cycle while the
// result is not stalled; the link of the current head is prefetched from the link
// memory whenever the head changes, so a pop never waits on the memory read port.
// Receiver stall: the result register holds; the request register fills behind
// it and in_stall rises while both are occupied.
// Configuration: APB writes to low_bound (0x0) and high_bound (0x8), 64-bit
// data. The user must write only while no transaction is in flight; the
// block does not enforce this. pready is always high. Reset: list empty,
// count zero, both bounds zero, so every free is rejected until high_bound is
// written. The link memory needs no clearing: only links written by a push are
// ever read. Free list is filled by software issuing frees for each page.
module page_free_list_allocator #(
	parameter int unsigned NUM_PAGES  = pfla_pkg::NUM_PAGES_DEF,
	parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [pfla_pkg::ADDR_W-1:0]   page_addr,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfla_pkg::STATUS_W-1:0] status,
	output logic [pfla_pkg::ADDR_W-1:0]   alloc_addr,
	output logic [pfla_pkg::PAGES_W-1:0]  free_pages,
	output logic [pfla_pkg::BYTES_W-1:0]  free_bytes,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfla_pkg::PADDR_W-1:0]  paddr,
	input  logic [pfla_pkg::DATA_W-1:0]   pwdata,
	output logic [pfla_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import pfla_pkg::*;

	localparam int unsigned IDX_W = $clog2(NUM_PAGES);
	localparam int unsigned CNT_W = $clog2(NUM_PAGES + 1);

	// configuration registers
	logic [ADDR_W-1:0] low_bound_q;
	logic [ADDR_W-1:0] high_bound_q;

	// request stage
	logic              valid_s1;
	logic              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] alloc_addr_q;
	logic [PAGES_W-1:0] free_pages_q;
	logic [BYTES_W-1:0] free_bytes_q;

	logic              adv;
	logic              fire;
	logic              is_free;
	logic [ADDR_W-1:0] base;
	logic              addr_ok;
	logic [IDX_W-1:0]  push_idx;
	logic [IDX_W-1:0]  head_idx;
	logic              head_valid;
	logic [CNT_W-1:0]  count_next;
	list_op_t          op;

	status_t           status_d;
	logic [ADDR_W-1:0] alloc_addr_d;
	logic [63:0]       addr_wide;
	logic [63:0]       pages_wide;
	logic [63:0]       bytes_wide;

	// apb register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q  <= '0;
			high_bound_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[3] == REG_HIGH) begin
				high_bound_q <= pwdata[ADDR_W-1:0];
			end else begin
				low_bound_q <= pwdata[ADDR_W-1:0];
			end
		end
	end

	// apb read data
	assign prdata = (paddr[3] == REG_LOW) ? DATA_W'(low_bound_q) : DATA_W'(high_bound_q);
	assign pready = 1'b1;

	// handshake: the request stage moves when the result register is free
	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			addr_s1 <= page_addr;
		end
	end

	// free address check
	pfla_addr_check #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.IDX_W      (IDX_W)
	) u_check (
		.page_addr  (addr_s1),
		.low_bound  (low_bound_q),
		.high_bound (high_bound_q),
		.base       (base),
		.addr_ok    (addr_ok),
		.page_idx   (push_idx)
	);

	// list update for this transaction
	assign is_free = (cmd_s1 == CMD_FREE);
	assign op.push = fire && is_free && addr_ok;
	assign op.pop  = fire && !is_free && head_valid;

	pfla_list #(
		.NUM_PAGES  (NUM_PAGES),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.push_idx   (push_idx),
		.head_idx   (head_idx),
		.head_valid (head_valid),
		.count_next (count_next)
	);

	// result fields
	assign addr_wide  = 64'(base) + (64'(head_idx) << PAGE_SHIFT);
	assign pages_wide = 64'(count_next);
	assign bytes_wide = pages_wide << PAGE_SHIFT;

	always_comb begin
		status_d     = ST_OK;
		alloc_addr_d = '0;
		if (is_free) begin
			if (!addr_ok) begin
				status_d = ST_REJECT;
			end
		end else if (head_valid) begin
			alloc_addr_d = addr_wide[ADDR_W-1:0];
		end else begin
			status_d = ST_EMPTY;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= status_d;
			alloc_addr_q <= alloc_addr_d;
			free_pages_q <= pages_wide[PAGES_W-1:0];
			free_bytes_q <= bytes_wide[BYTES_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign alloc_addr = alloc_addr_q;
	assign free_pages = free_pages_q;
	assign free_bytes = free_bytes_q;

endmodule

>>> src/pfla_checker.sv
`include "assert_macros.svh"

module pfla_checker #(
	parameter int unsigned NUM_PAGES = pfla_pkg::NUM_PAGES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pfla_pkg::STATUS_W-1:0] status,
	input logic [pfla_pkg::ADDR_W-1:0]   alloc_addr,
	input logic [pfla_pkg::PAGES_W-1:0]  free_pages
);
	import pfla_pkg::*;

	// a stalled result stays offered with the same status
	`PFLA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "stalled result changed")

	// an empty list means no pages are counted and no address is handed out
	`PFLA_ASSERT(a_empty_zero, clk, arst_n, (out_valid && status == ST_EMPTY) |-> (free_pages == '0 && alloc_addr == '0), "empty status with pages or address")

	// a rejected free never returns an address
	`PFLA_ASSERT(a_reject_addr, clk, arst_n, (out_valid && status == ST_REJECT) |-> (alloc_addr == '0), "rejected free returned an address")

	// count never exceeds capacity
	`PFLA_ASSERT(a_count_cap, clk, arst_n, out_valid |-> (32'(free_pages) <= NUM_PAGES), "free page count above capacity")

endmodule

bind page_free_list_allocator pfla_checker #(
	.NUM_PAGES (NUM_PAGES)
) u_pfla_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.alloc_addr (alloc_addr),
	.free_pages (free_pages)
);
